>>> rtl/deadline_ordered_ready_queue_assert.svh
// assertion macros for the deadline ordered ready queue
`ifndef DEADLINE_ORDERED_READY_QUEUE_ASSERT_SVH
`define DEADLINE_ORDERED_READY_QUEUE_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define DORQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define DORQ_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/dorq_pkg.sv
// types, constants and codes of the deadline ordered ready queue
`default_nettype none

package dorq_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_POP    = 2'd1;
    localparam logic [1:0] FN_REMOVE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_PRESENT   = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  task_id;
        logic [31:0] deadline;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  removed_id;
        logic [31:0] removed_deadline;
        logic [7:0]  head_id;
        logic [31:0] head_deadline;
        logic [4:0]  entry_count;
    } t_out;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [31:0] deadline;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

>>> rtl/dorq_store.sv
// slot memory: one write port, one registered read port
`default_nettype none

module dorq_store (
    input  wire logic              i_clk,
    input  wire dorq_pkg::t_mem_req i_req,
    output dorq_pkg::t_entry       o_rdata
);
    import dorq_pkg::*;

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/deadline_ordered_ready_queue.sv
// Deadline ordered ready queue, sorted slots in one memory, slot 0 is the head.
// One word at a time: scan of the held slots, shift of the slots behind the position, then
// head read and result; the next word is taken only once the result has been registered.
// Reset zeroes the count and the control; slot memory is not cleared and needs no pass.
`default_nettype none

module deadline_ordered_ready_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire dorq_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output dorq_pkg::t_out    o_out_data
);
    import dorq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SHUP = 3'd2;
    localparam logic [2:0] S_SHDN = 3'd3;
    localparam logic [2:0] S_HEAD = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [1:0]       r_func, n_func;
    logic [7:0]       r_id, n_id;
    logic [31:0]      r_dl, n_dl;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic             r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_found, n_found;
    logic             r_present, n_present;
    logic [IDX_W-1:0] r_pos, n_pos;
    t_entry           r_rem, n_rem;
    logic [2:0]       r_status, n_status;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    t_mem_req w_req;
    t_entry   w_rdata;
    logic     w_match;

    dorq_store u_store (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_id        = r_id;
        n_dl        = r_dl;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_found     = r_found;
        n_present   = r_present;
        n_pos       = r_pos;
        n_rem       = r_rem;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_req       = '0;
        w_match     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func    = i_in_data.func;
                    n_id      = i_in_data.task_id;
                    n_dl      = i_in_data.deadline;
                    n_ptr     = '0;
                    n_found   = 1'b0;
                    n_present = 1'b0;
                    n_pos     = '0;
                    n_rem     = '0;
                    n_status  = ST_OK;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // look at the slot returned by last cycle's read
                if (r_rd_vld) begin
                    if (r_func == FN_INSERT) begin
                        if (w_rdata.task_id == r_id) begin
                            n_present = 1'b1;
                        end
                        if (!r_found && w_rdata.deadline >= r_dl) begin
                            n_found = 1'b1;
                            n_pos   = r_rd_idx;
                        end
                    end else begin
                        if (r_func == FN_POP) begin
                            w_match = (r_rd_idx == '0);
                        end else if (r_func == FN_REMOVE) begin
                            w_match = (w_rdata.task_id == r_id);
                        end
                        if (w_match && !r_found) begin
                            n_found = 1'b1;
                            n_pos   = r_rd_idx;
                            n_rem   = w_rdata;
                        end
                    end
                end
                if (r_ptr < r_cnt) begin
                    w_req.re    = 1'b1;
                    w_req.raddr = r_ptr[IDX_W-1:0];
                    n_rd_vld    = 1'b1;
                    n_rd_idx    = r_ptr[IDX_W-1:0];
                    n_ptr       = r_ptr + 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = S_HEAD;
                    unique case (r_func)
                        FN_INSERT: begin
                            if (r_present) begin
                                n_status = ST_PRESENT;
                            end else if (r_cnt == CNT_W'(MAX_ENTRIES)) begin
                                n_status = ST_FULL;
                            end else begin
                                if (!r_found) begin
                                    n_pos = r_cnt[IDX_W-1:0];
                                end
                                n_ptr   = r_cnt;
                                n_state = S_SHUP;
                            end
                        end
                        FN_POP, FN_REMOVE: begin
                            if (!r_found) begin
                                n_status = (r_func == FN_POP) ? ST_EMPTY : ST_NOT_FOUND;
                            end else begin
                                n_ptr   = CNT_W'(r_pos) + 1'b1;
                                n_state = S_SHDN;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SHUP: begin
                // walk down from the tail, each slot moves one place back
                if (r_rd_vld) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_rd_idx + 1'b1;
                    w_req.wdata = w_rdata;
                end
                if (r_ptr > CNT_W'(r_pos)) begin
                    w_req.re    = 1'b1;
                    w_req.raddr = IDX_W'(r_ptr - 1'b1);
                    n_rd_vld    = 1'b1;
                    n_rd_idx    = IDX_W'(r_ptr - 1'b1);
                    n_ptr       = r_ptr - 1'b1;
                end else if (!r_rd_vld) begin
                    w_req.we            = 1'b1;
                    w_req.waddr         = r_pos;
                    w_req.wdata.task_id = r_id;
                    w_req.wdata.deadline = r_dl;
                    n_cnt               = r_cnt + 1'b1;
                    n_state             = S_HEAD;
                end
            end
            S_SHDN: begin
                // close the gap, each slot behind moves one place forward
                if (r_rd_vld) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_rd_idx - 1'b1;
                    w_req.wdata = w_rdata;
                end
                if (r_ptr < r_cnt) begin
                    w_req.re    = 1'b1;
                    w_req.raddr = r_ptr[IDX_W-1:0];
                    n_rd_vld    = 1'b1;
                    n_rd_idx    = r_ptr[IDX_W-1:0];
                    n_ptr       = r_ptr + 1'b1;
                end else if (!r_rd_vld) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (r_cnt != '0) begin
                    w_req.re    = 1'b1;
                    w_req.raddr = '0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // read data stays put here, no read is issued
                if (!r_out_valid || i_out_ready) begin
                    n_out.status           = r_status;
                    n_out.removed_id       = r_rem.task_id;
                    n_out.removed_deadline = r_rem.deadline;
                    n_out.head_id          = (r_cnt != '0) ? w_rdata.task_id : 8'd0;
                    n_out.head_deadline    = (r_cnt != '0) ? w_rdata.deadline : 32'd0;
                    n_out.entry_count      = 5'(r_cnt);
                    n_out_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_id      <= n_id;
        r_dl      <= n_dl;
        r_ptr     <= n_ptr;
        r_rd_idx  <= n_rd_idx;
        r_found   <= n_found;
        r_present <= n_present;
        r_pos     <= n_pos;
        r_rem     <= n_rem;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "deadline_ordered_ready_queue_assert.svh"

    `DORQ_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(MAX_ENTRIES), "entry count above capacity")
    `DORQ_NEVER(a_write_outside_shift, w_req.we && r_state != S_SHUP && r_state != S_SHDN, "slot write outside a shift")
    `DORQ_ASSERT(a_out_from_done, $rose(o_out_valid) |-> $past(r_state) == S_DONE, "result raised outside done")
    `DORQ_ASSERT(a_cnt_step, $past(i_rst_n) && r_cnt != $past(r_cnt) |-> ($past(r_state) == S_SHUP || $past(r_state) == S_SHDN), "count changed outside a shift")
    `DORQ_ASSERT(a_full_count, o_out_valid && o_out_data.status == ST_FULL |-> o_out_data.entry_count == 5'(MAX_ENTRIES), "full reported below capacity")

endmodule

`default_nettype wire
